### hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int KB_SHIFT  = 10;
  localparam int KB_LOW    = 1024;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic REG_UPPER_KB   = 1'b0;
  localparam logic REG_KERNEL_END = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] allocated_address;
    logic [15:0] free_page_count;
    logic [15:0] used_page_count;
    logic [15:0] total_page_count;
  } result_t;

endpackage

### hdl/bpa_ram.sv
// Single-port bitmap memory with a registered read.
module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic                           re,
  input  logic [AW-1:0]                  addr,
  input  logic [bpa_pkg::WORD_BITS-1:0]  wdata,
  output logic [bpa_pkg::WORD_BITS-1:0]  rdata
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/bpa_core.sv
// Allocator sequencer: word scan, read-modify-write of the bitmap, map sweeps and counts.
module bpa_core #(
  parameter int MAP_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096,
  parameter int MAP_WORDS  = (MAP_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS,
  parameter int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [31:0]                   in_page_address,
  input  logic [21:0]                   upper_memory_kb,
  input  logic [31:0]                   kernel_end_address,
  output logic                          res_valid,
  input  logic                          res_take,
  output bpa_pkg::result_t              res,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_addr,
  output logic [bpa_pkg::WORD_BITS-1:0] ram_wdata,
  input  logic [bpa_pkg::WORD_BITS-1:0] ram_rdata
);

  localparam int CW    = $clog2(MAP_PAGES + 1);
  localparam int SHIFT = $clog2(PAGE_BYTES);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [AW-1:0]                 wa_r;
  logic                          sweep_res_r;
  logic [AW:0]                   issue_r;
  logic                          chk_v_r;
  logic [AW-1:0]                 chk_addr_r;
  logic [AW-1:0]                 fword_r;
  logic [bpa_pkg::BIT_W-1:0]     fbit_r;
  logic [CW-1:0]                 managed_r;
  logic [CW-1:0]                 used_r;
  logic [CW-1:0]                 klimit_r;
  bpa_pkg::status_t              status_r;
  logic [31:0]                   addr_r;

  // bits of word w that lie below a page limit
  function automatic logic [bpa_pkg::WORD_BITS-1:0] word_mask(input logic [AW:0] w,
                                                             input logic [CW-1:0] limit);
    logic [31:0] lw;
    logic [31:0] ww;
    logic [bpa_pkg::BIT_W-1:0] lb;
    lw = 32'(limit) >> bpa_pkg::BIT_W;
    ww = 32'(w);
    lb = limit[bpa_pkg::BIT_W-1:0];
    if (ww < lw) begin
      word_mask = '1;
    end else if (ww == lw) begin
      word_mask = (32'd1 << lb) - 32'd1;
    end else begin
      word_mask = '0;
    end
  endfunction

  function automatic logic [bpa_pkg::BIT_W-1:0] lowest_bit(
      input logic [bpa_pkg::WORD_BITS-1:0] v);
    lowest_bit = '0;
    for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        lowest_bit = bpa_pkg::BIT_W'(i);
      end
    end
  endfunction

  // init sizing
  logic [22:0]                   kb_total;
  logic [32:0]                   region_pages;
  logic [32:0]                   kern_pages;
  logic [CW-1:0]                 managed_init;
  logic [CW-1:0]                 kpages_init;
  // free decode
  logic [31:0]                   free_page;
  logic                          free_in_range;
  logic [AW-1:0]                 free_word;
  // scan
  logic [AW:0]                   nwords;
  logic                          more;
  logic [bpa_pkg::WORD_BITS-1:0] cand;
  logic [bpa_pkg::WORD_BITS-1:0] hit_one;
  logic                          hit;
  logic [bpa_pkg::BIT_W-1:0]     hit_bit;
  logic [AW+bpa_pkg::BIT_W-1:0]  hit_page;
  logic [CW-1:0]                 free_cnt;

  assign kb_total     = 23'(upper_memory_kb) + 23'(bpa_pkg::KB_LOW);
  assign region_pages = (33'(kb_total) << bpa_pkg::KB_SHIFT) >> SHIFT;
  assign kern_pages   = 33'(kernel_end_address >> SHIFT) + 33'd1;
  assign managed_init = (region_pages > 33'(MAP_PAGES)) ? CW'(MAP_PAGES) : CW'(region_pages);
  assign kpages_init  = (kern_pages > 33'(MAP_PAGES)) ? CW'(MAP_PAGES) : CW'(kern_pages);

  assign free_page     = in_page_address >> SHIFT;
  assign free_in_range = free_page < 32'(managed_r);
  assign free_word     = AW'(free_page >> bpa_pkg::BIT_W);

  assign nwords   = (AW+1)'((32'(managed_r) + 32'd31) >> bpa_pkg::BIT_W);
  assign more     = issue_r < nwords;
  assign cand     = ~ram_rdata & word_mask({1'b0, chk_addr_r}, managed_r);
  assign hit_one  = cand & (~cand + 32'd1);
  assign hit      = chk_v_r && (cand != '0);
  assign hit_bit  = lowest_bit(cand);
  assign hit_page = {chk_addr_r, hit_bit};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign free_cnt  = (managed_r > used_r) ? managed_r - used_r : '0;

  always_comb begin
    res.status            = status_r;
    res.allocated_address = addr_r;
    res.free_page_count   = 16'(free_cnt);
    res.used_page_count   = 16'(used_r);
    res.total_page_count  = 16'(managed_r);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_command == bpa_pkg::CMD_FREE && free_in_range) begin
          ram_re   = 1'b1;
          ram_addr = free_word;
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_addr  = chk_addr_r;
          ram_wdata = ram_rdata | hit_one;
        end else if (more) begin
          ram_re   = 1'b1;
          ram_addr = issue_r[AW-1:0];
        end
      end
      S_FREE_CHK: begin
        if (ram_rdata[fbit_r]) begin
          ram_we    = 1'b1;
          ram_addr  = fword_r;
          ram_wdata = ram_rdata & ~(32'd1 << fbit_r);
        end
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = wa_r;
        ram_wdata = word_mask({1'b0, wa_r}, klimit_r);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      wa_r        <= '0;
      sweep_res_r <= 1'b0;
      klimit_r    <= '0;
      managed_r   <= '0;
      used_r      <= '0;
      chk_v_r     <= 1'b0;
      issue_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_command)
              bpa_pkg::CMD_ALLOC: begin
                issue_r <= '0;
                chk_v_r <= 1'b0;
                state_r <= S_SCAN;
              end
              bpa_pkg::CMD_FREE: begin
                addr_r <= '0;
                if (free_in_range) begin
                  fword_r <= free_word;
                  fbit_r  <= free_page[bpa_pkg::BIT_W-1:0];
                  state_r <= S_FREE_CHK;
                end else begin
                  status_r <= bpa_pkg::ST_IGNORED;
                  state_r  <= S_DONE;
                end
              end
              bpa_pkg::CMD_INIT: begin
                managed_r   <= managed_init;
                used_r      <= kpages_init;
                klimit_r    <= kpages_init;
                wa_r        <= '0;
                sweep_res_r <= 1'b1;
                state_r     <= S_SWEEP;
              end
              default: begin
                status_r <= bpa_pkg::ST_DONE;
                addr_r   <= '0;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_v_r    <= ram_re;
          chk_addr_r <= issue_r[AW-1:0];
          if (ram_re) begin
            issue_r <= issue_r + 1'b1;
          end
          if (hit) begin
            used_r   <= used_r + 1'b1;
            status_r <= bpa_pkg::ST_DONE;
            addr_r   <= 32'(hit_page) << SHIFT;
            state_r  <= S_DONE;
          end else if (!more) begin
            status_r <= bpa_pkg::ST_OOM;
            addr_r   <= '0;
            state_r  <= S_DONE;
          end
        end
        S_FREE_CHK: begin
          if (ram_rdata[fbit_r]) begin
            used_r   <= used_r - 1'b1;
            status_r <= bpa_pkg::ST_DONE;
          end else begin
            status_r <= bpa_pkg::ST_IGNORED;
          end
          state_r <= S_DONE;
        end
        S_SWEEP: begin
          wa_r     <= wa_r + 1'b1;
          status_r <= bpa_pkg::ST_DONE;
          addr_r   <= '0;
          if (wa_r == LAST_WORD) begin
            state_r <= sweep_res_r ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("bitmap read and write in one cycle");

  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (state_r == S_DONE && status_r == bpa_pkg::ST_DONE))
    else $error("scan hit did not complete the allocation");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (used_r == $past(used_r) + 1'b1))
    else $error("used count not bumped on allocation");

  a_oom_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == bpa_pkg::ST_OOM) |-> (res.allocated_address == '0))
    else $error("out-of-memory result carries an address");

endmodule

### hdl/bitmap_page_allocator.sv
// Bitmap first-fit page allocator top level: config registers, result register, bitmap memory.
//
// One transaction at a time. The used bitmap sits in a single-port memory of
// ceil(MAP_PAGES/32) words with a registered read. An alloc scans one word per
// cycle from the bottom of the map; a free is a read-modify-write of one word;
// an init rewrites every word of the map. After reset the block first runs a
// clearing pass over every word of the map with in_ready low. A finished result
// waits in the output register while the next transaction is taken. PAGE_BYTES
// must be a power of two.
module bitmap_page_allocator #(
  parameter int MAP_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_page_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_allocated_address,
  output logic [15:0] out_free_page_count,
  output logic [15:0] out_used_page_count,
  output logic [15:0] out_total_page_count
);

  localparam int MAP_WORDS = (MAP_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [21:0]                   upper_memory_kb_r;
  logic [31:0]                   kernel_end_address_r;
  logic                          out_valid_r;
  bpa_pkg::result_t              out_r;
  logic                          res_valid;
  logic                          res_take;
  bpa_pkg::result_t              res;
  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_addr;
  logic [bpa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bpa_pkg::WORD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_memory_kb_r    <= '0;
      kernel_end_address_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpa_pkg::REG_UPPER_KB:   upper_memory_kb_r    <= cfg_wdata[21:0];
        bpa_pkg::REG_KERNEL_END: kernel_end_address_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_allocated_address = out_r.allocated_address;
  assign out_free_page_count   = out_r.free_page_count;
  assign out_used_page_count   = out_r.used_page_count;
  assign out_total_page_count  = out_r.total_page_count;

  bpa_core #(
    .MAP_PAGES  (MAP_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .MAP_WORDS  (MAP_WORDS),
    .AW         (AW)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_page_address    (in_page_address),
    .upper_memory_kb    (upper_memory_kb_r),
    .kernel_end_address (kernel_end_address_r),
    .res_valid          (res_valid),
    .res_take           (res_take),
    .res                (res),
    .ram_we             (ram_we),
    .ram_re             (ram_re),
    .ram_addr           (ram_addr),
    .ram_wdata          (ram_wdata),
    .ram_rdata          (ram_rdata)
  );

  bpa_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

### tb/sv/bitmap_page_allocator_tb.sv
// Self-checking testbench for the bitmap page allocator: directed and random commands.
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;

  localparam int MAP_PAGES    = 32768;
  localparam int PAGE_BYTES   = 4096;
  localparam int MAP_WORDS    = MAP_PAGES / bpa_pkg::WORD_BITS;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE       = 40;
  localparam int HELD_MAX     = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // predicted allocator state plus the queue of results still owed
  class page_ledger;
    logic [31:0]       frame_used [MAP_WORDS];
    int unsigned       region_pages;
    int unsigned       frames_in_use;
    logic [21:0]       upper_kb;
    logic [31:0]       kernel_end;
    bpa_pkg::result_t  due_results [$];
    int unsigned       held_pages [$];
    int unsigned       mismatches;

    function new();
      foreach (frame_used[w]) frame_used[w] = '0;
      region_pages  = 0;
      frames_in_use = 0;
      upper_kb      = '0;
      kernel_end    = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == bpa_pkg::REG_UPPER_KB) upper_kb = value[21:0];
      else kernel_end = value;
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] addr);
      bpa_pkg::result_t r;
      int unsigned      p;
      bit               found;
      longint unsigned  span;
      longint unsigned  kp;
      r = '0;
      r.status = bpa_pkg::ST_DONE;
      case (cmd)
        bpa_pkg::CMD_ALLOC: begin
          found = 0;
          p = 0;
          while (p < region_pages && !found) begin
            if (p % bpa_pkg::WORD_BITS == 0 && frame_used[p / bpa_pkg::WORD_BITS] == '1)
              p += bpa_pkg::WORD_BITS;
            else if (!frame_used[p / bpa_pkg::WORD_BITS][p % bpa_pkg::WORD_BITS]) begin
              frame_used[p / bpa_pkg::WORD_BITS][p % bpa_pkg::WORD_BITS] = 1'b1;
              found = 1;
            end else
              p++;
          end
          if (found) begin
            frames_in_use++;
            r.allocated_address = 32'(p * PAGE_BYTES);
            held_pages.push_back(p);
            if (held_pages.size() > HELD_MAX) void'(held_pages.pop_front());
          end else
            r.status = bpa_pkg::ST_OOM;
        end
        bpa_pkg::CMD_FREE: begin
          p = addr / PAGE_BYTES;
          if (p < region_pages &&
              frame_used[p / bpa_pkg::WORD_BITS][p % bpa_pkg::WORD_BITS]) begin
            frame_used[p / bpa_pkg::WORD_BITS][p % bpa_pkg::WORD_BITS] = 1'b0;
            frames_in_use--;
          end else
            r.status = bpa_pkg::ST_IGNORED;
        end
        bpa_pkg::CMD_INIT: begin
          span = (longint'(upper_kb) + bpa_pkg::KB_LOW) * 1024 / PAGE_BYTES;
          if (span > MAP_PAGES) span = MAP_PAGES;
          region_pages = int'(span);
          kp = longint'(kernel_end) / PAGE_BYTES + 1;
          if (kp > MAP_PAGES) kp = MAP_PAGES;
          foreach (frame_used[w])
            frame_used[w] = (w < kp / bpa_pkg::WORD_BITS) ? '1 : '0;
          if (kp % bpa_pkg::WORD_BITS != 0)
            frame_used[kp / bpa_pkg::WORD_BITS] = (32'h1 << (kp % bpa_pkg::WORD_BITS)) - 1;
          frames_in_use = int'(kp);
        end
        default: ;
      endcase
      r.free_page_count  = (region_pages > frames_in_use) ?
                           16'(region_pages - frames_in_use) : 16'd0;
      r.used_page_count  = 16'(frames_in_use);
      r.total_page_count = 16'(region_pages);
      due_results.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      $display("ERROR %0t: %s", $time, what);
    endtask

    task check_result(bpa_pkg::result_t got);
      bpa_pkg::result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d exp %0d", got.status, want.status));
      if (got.allocated_address !== want.allocated_address)
        report($sformatf("address got %h exp %h", got.allocated_address,
                         want.allocated_address));
      if (got.free_page_count !== want.free_page_count)
        report($sformatf("free count got %0d exp %0d", got.free_page_count,
                         want.free_page_count));
      if (got.used_page_count !== want.used_page_count)
        report($sformatf("used count got %0d exp %0d", got.used_page_count,
                         want.used_page_count));
      if (got.total_page_count !== want.total_page_count)
        report($sformatf("total count got %0d exp %0d", got.total_page_count,
                         want.total_page_count));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_page_address;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_allocated_address;
  logic [15:0] out_free_page_count;
  logic [15:0] out_used_page_count;
  logic [15:0] out_total_page_count;

  page_ledger       ledger = new();
  bpa_pkg::result_t seen;
  bit               calm_in;
  bit               calm_out;
  int unsigned      stall_left;
  int unsigned      cycle_count;

  bitmap_page_allocator #(
    .MAP_PAGES (MAP_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_page_address      (in_page_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_allocated_address(out_allocated_address),
    .out_free_page_count  (out_free_page_count),
    .out_used_page_count  (out_used_page_count),
    .out_total_page_count (out_total_page_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one transaction on the command channel
  task automatic send_command(logic [1:0] cmd, logic [31:0] addr);
    int unsigned gap;
    gap = calm_in ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command      = cmd;
    in_page_address = addr;
    in_valid        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_command(cmd, addr);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    ledger.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_both(logic [31:0] kb_word, logic [31:0] ke_word);
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(bpa_pkg::REG_UPPER_KB, kb_word);
      write_reg(bpa_pkg::REG_KERNEL_END, ke_word);
    end else begin
      write_reg(bpa_pkg::REG_KERNEL_END, ke_word);
      write_reg(bpa_pkg::REG_UPPER_KB, kb_word);
    end
  endtask

  task automatic random_setting();
    int unsigned kind;
    int unsigned span;
    int unsigned kp;
    logic [31:0] kb_word;
    logic [31:0] ke_word;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // small region with only a few free frames above the kernel
      kb_word = $urandom_range(0, 3072);
      span    = (kb_word + bpa_pkg::KB_LOW) * 1024 / PAGE_BYTES;
      kp      = span - $urandom_range(0, 48);
      if ($urandom_range(0, 9) == 0) kp += $urandom_range(0, 64);
      if (kp == 0) kp = 1;
      ke_word = (kp - 1) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
    end else if (kind <= 7) begin
      kb_word = $urandom_range(0, 4193280);
      ke_word = $urandom_range(0, 2048 * PAGE_BYTES);
    end else if (kind == 8) begin
      kb_word = $urandom();
      ke_word = $urandom();
    end else begin
      kb_word = {10'($urandom()), 22'h3FFFFF};
      ke_word = '0;
    end
    set_both(kb_word, ke_word);
  endtask

  task automatic random_command();
    int unsigned r;
    int unsigned pg;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_command(bpa_pkg::CMD_ALLOC, $urandom());
    else if (r < 75 && ledger.held_pages.size() > 0) begin
      pg = ledger.held_pages[$urandom_range(0, ledger.held_pages.size() - 1)];
      send_command(bpa_pkg::CMD_FREE,
                   32'(pg * PAGE_BYTES) | 32'($urandom_range(0, PAGE_BYTES - 1)));
    end else if (r < 85) begin
      pg = $urandom_range(0, ledger.region_pages + 16);
      send_command(bpa_pkg::CMD_FREE,
                   32'(pg * PAGE_BYTES) | 32'($urandom_range(0, PAGE_BYTES - 1)));
    end else if (r < 92)
      send_command(bpa_pkg::CMD_FREE, $urandom());
    else if (r < 96)
      send_command(bpa_pkg::CMD_INIT, $urandom());
    else
      send_command(CMD_UNUSED, $urandom());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.status            = out_status;
      seen.allocated_address = out_allocated_address;
      seen.free_page_count   = out_free_page_count;
      seen.used_page_count   = out_used_page_count;
      seen.total_page_count  = out_total_page_count;
      ledger.check_result(seen);
    end
  end

  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    calm_out   = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!calm_out && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bitmap_page_allocator_tb failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = bpa_pkg::REG_UPPER_KB;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_command      = bpa_pkg::CMD_ALLOC;
    in_page_address = '0;
    calm_in         = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // before any init, then init from reset register values
    send_command(bpa_pkg::CMD_ALLOC, '0);
    send_command(bpa_pkg::CMD_FREE, '0);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF);
    send_command(bpa_pkg::CMD_INIT, '0);
    send_command(bpa_pkg::CMD_ALLOC, '0);
    send_command(bpa_pkg::CMD_FREE, 32'h0000_1FFF);

    // minimum region, few frames above the kernel: run out
    set_both('0, 250 * PAGE_BYTES + PAGE_BYTES - 1);
    send_command(bpa_pkg::CMD_INIT, '0);
    repeat (6) send_command(bpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_command(bpa_pkg::CMD_FREE, 32'h000F_F000);
    send_command(bpa_pkg::CMD_FREE, 32'h000F_F000);
    send_command(bpa_pkg::CMD_FREE, 300 * PAGE_BYTES);
    send_command(bpa_pkg::CMD_FREE, 32'hFFFF_FFFF);
    send_command(bpa_pkg::CMD_FREE, '0);
    send_command(bpa_pkg::CMD_ALLOC, '0);

    // capped region, whole map reserved
    set_both(4193280, 32'hFFFF_FFFF);
    send_command(bpa_pkg::CMD_INIT, '0);
    send_command(bpa_pkg::CMD_ALLOC, '0);
    send_command(bpa_pkg::CMD_FREE, (MAP_PAGES - 1) * PAGE_BYTES);

    // kernel reservation beyond the region: free count saturates
    set_both('0, 1000 * PAGE_BYTES);
    send_command(bpa_pkg::CMD_INIT, '0);
    send_command(bpa_pkg::CMD_FREE, 100 * PAGE_BYTES);
    send_command(bpa_pkg::CMD_ALLOC, '0);

    for (phase = 0; phase < 12; phase++) begin
      random_setting();
      calm_in = ($urandom_range(0, 3) == 0);
      send_command(bpa_pkg::CMD_INIT, $urandom());
      n = $urandom_range(35, 55);
      repeat (n) begin
        if ($urandom_range(0, 49) == 0) wait_idle();
        random_command();
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (ledger.mismatches == 0)
      $display("bitmap_page_allocator_tb passed");
    else
      $display("bitmap_page_allocator_tb failed");
    $finish;
  end

endmodule

### files.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_core.sv
hdl/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_tb.sv
